// ===== hw/rtl/dss_pkg.sv =====
`default_nettype none
package dss_pkg;

  localparam int unsigned AxisW    = 16;
  localparam int unsigned StepW    = 24;
  localparam int unsigned TravelW  = 40;
  localparam int unsigned MagW     = 18;
  localparam int unsigned SumW     = 32;
  localparam int unsigned CntW     = 16;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 40;

  // decel rule: last * 4 < peak
  localparam int unsigned QuarterShift = 2;

  localparam logic [CntW-1:0]    CntMax       = '1;
  localparam logic [TravelW-1:0] TravelMax    = '1;
  localparam logic [CntW-1:0]    MinSamplesRst = CntW'(1);
  localparam logic [CntW-1:0]    MaxTicksRst   = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DRIVE_COMMAND = 4'd0,
    CFG_TARE_X        = 4'd1,
    CFG_TARE_Y        = 4'd2,
    CFG_TARE_Z        = 4'd3,
    CFG_MAX_TRAVEL    = 4'd4,
    CFG_MIN_TRAVEL    = 4'd5,
    CFG_MIN_SAMPLES   = 4'd6,
    CFG_MAX_TICKS     = 4'd7
  } cfg_index_e;

  typedef struct packed {
    logic                    start_run;
    logic                    motion_valid;
    logic signed [StepW-1:0] travel_step_um;
    logic                    sample_valid;
    logic [AxisW-1:0]        sample_id;
    logic signed [AxisW-1:0] raw_x;
    logic signed [AxisW-1:0] raw_y;
    logic signed [AxisW-1:0] raw_z;
    logic signed [AxisW-1:0] accel_x_mg;
    logic signed [AxisW-1:0] accel_y_mg;
    logic signed [AxisW-1:0] accel_z_mg;
  } in_item_t;

  typedef struct packed {
    logic signed [AxisW-1:0] x;
    logic signed [AxisW-1:0] y;
    logic signed [AxisW-1:0] z;
  } axes_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dss_mag.sv =====
`default_nettype none
module dss_mag (
  input  dss_pkg::axes_t             accel_i,
  input  dss_pkg::axes_t             tare_i,
  output logic [dss_pkg::MagW-1:0]   mag_o
);
  import dss_pkg::*;

  function automatic logic [AxisW-1:0] abs_diff(logic signed [AxisW-1:0] a,
                                                 logic signed [AxisW-1:0] b);
    logic signed [AxisW:0] d;
    logic [AxisW:0]        m;
    d = {a[AxisW-1], a} - {b[AxisW-1], b};
    m = d[AxisW] ? (AxisW+1)'(-d) : d;
    return m[AxisW-1:0];
  endfunction

  logic [AxisW-1:0] dx, dy, dz;

  assign dx = abs_diff(accel_i.x, tare_i.x);
  assign dy = abs_diff(accel_i.y, tare_i.y);
  assign dz = abs_diff(accel_i.z, tare_i.z);

  assign mag_o = MagW'(dx) + MagW'(dy) + MagW'(dz);

endmodule
`default_nettype wire

// ===== hw/rtl/drive_and_sample_sequencer.sv =====
`default_nettype none
// Drive-and-sample sequencer: one input beat per control tick, one result beat
// per input beat.
// Channels: in_* carries the tick (start pulse, encoder step, accelerometer
// sample), out_* carries the run status, motor command and running totals,
// cfg_* writes the configuration registers by index (cfg_ready_o is always
// high; indexes past the list are ignored). Write configuration only while
// no tick is in flight.
// A tick accepted goes into the input register; its result is registered in
// the result register, which drives out_*, once that register is free.
// Throughput: one tick per cycle while the receiver does not stall; the whole
// tick update (40-bit travel add, three-axis magnitude, peak and stop
// compares) sits between the input register and the result register.
// Reset clears run state and loads register defaults; the first tick after
// reset starts a run and writes drive_command to the motors (zero if it stops).
// When the receiver stalls, the result register holds; the input register
// still takes one more beat, then in_ready_o drops until out_ready_i returns.
module drive_and_sample_sequencer (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [dss_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [dss_pkg::CfgDataW-1:0]     cfg_data_i,

  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             start_run_i,
  input  logic                             motion_valid_i,
  input  logic signed [dss_pkg::StepW-1:0] travel_step_um_i,
  input  logic                             sample_valid_i,
  input  logic [dss_pkg::AxisW-1:0]        sample_id_i,
  input  logic signed [dss_pkg::AxisW-1:0] raw_x_i,
  input  logic signed [dss_pkg::AxisW-1:0] raw_y_i,
  input  logic signed [dss_pkg::AxisW-1:0] raw_z_i,
  input  logic signed [dss_pkg::AxisW-1:0] accel_x_mg_i,
  input  logic signed [dss_pkg::AxisW-1:0] accel_y_mg_i,
  input  logic signed [dss_pkg::AxisW-1:0] accel_z_mg_i,

  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             run_finished_o,
  output logic                             run_failed_o,
  output logic                             motor_write_o,
  output logic signed [dss_pkg::AxisW-1:0] motor_value_o,
  output logic [dss_pkg::CntW-1:0]         samples_taken_o,
  output logic [dss_pkg::TravelW-1:0]      travel_total_um_o,
  output logic [dss_pkg::MagW-1:0]         last_magnitude_o,
  output logic [dss_pkg::MagW-1:0]         peak_magnitude_o,
  output logic signed [dss_pkg::SumW-1:0]  sum_x_o,
  output logic signed [dss_pkg::SumW-1:0]  sum_y_o,
  output logic signed [dss_pkg::SumW-1:0]  sum_z_o
);
  import dss_pkg::*;

  // configuration
  logic signed [AxisW-1:0] drive_cmd_q;
  axes_t                   tare_q;
  logic [TravelW-1:0]      max_travel_q, min_travel_q;
  logic [CntW-1:0]         min_samples_q, max_ticks_q;
  cfg_index_e              cfg_idx;

  assign cfg_ready_o = 1'b1;
  assign cfg_idx     = cfg_index_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_cmd_q   <= '0;
      tare_q        <= '0;
      max_travel_q  <= '0;
      min_travel_q  <= '0;
      min_samples_q <= MinSamplesRst;
      max_ticks_q   <= MaxTicksRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx)
        CFG_DRIVE_COMMAND: drive_cmd_q   <= cfg_data_i[AxisW-1:0];
        CFG_TARE_X:        tare_q.x      <= cfg_data_i[AxisW-1:0];
        CFG_TARE_Y:        tare_q.y      <= cfg_data_i[AxisW-1:0];
        CFG_TARE_Z:        tare_q.z      <= cfg_data_i[AxisW-1:0];
        CFG_MAX_TRAVEL:    max_travel_q  <= cfg_data_i[TravelW-1:0];
        CFG_MIN_TRAVEL:    min_travel_q  <= cfg_data_i[TravelW-1:0];
        CFG_MIN_SAMPLES:   min_samples_q <= cfg_data_i[CntW-1:0];
        CFG_MAX_TICKS:     max_ticks_q   <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic     in_vld_q, out_vld_q, out_free, advance;
  in_item_t in_q;

  assign out_free   = ~out_vld_q | out_ready_i;
  assign advance    = in_vld_q & out_free;
  assign in_ready_o = ~in_vld_q | out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= {start_run_i, motion_valid_i, travel_step_um_i, sample_valid_i,
               sample_id_i, raw_x_i, raw_y_i, raw_z_i,
               accel_x_mg_i, accel_y_mg_i, accel_z_mg_i};
    end
  end

  // run state
  logic                   fin_q, failed_q, cmd_sent_q, have_id_q;
  logic [CntW-1:0]        tick_q, count_q;
  logic [AxisW-1:0]       last_id_q;
  logic [TravelW-1:0]     travel_q;
  logic signed [SumW-1:0] sum_x_q, sum_y_q, sum_z_q;
  logic [MagW-1:0]        last_mag_q, peak_mag_q;

  logic                   fin_d, failed_d, cmd_sent_d, have_id_d;
  logic [CntW-1:0]        tick_d, count_d;
  logic [AxisW-1:0]       last_id_d;
  logic [TravelW-1:0]     travel_d;
  logic signed [SumW-1:0] sum_x_d, sum_y_d, sum_z_d;
  logic [MagW-1:0]        last_mag_d, peak_mag_d;

  logic                    mwrite, active, clr, cmd_b, fin_b, take, stop;
  logic                    tick_limit, decel;
  logic signed [AxisW-1:0] mvalue;
  logic [StepW-1:0]        step_abs;
  logic [TravelW:0]        travel_sum;
  logic [MagW-1:0]         mag;
  logic [MagW+QuarterShift-1:0] last_x4;

  dss_mag u_mag (
    .accel_i ({in_q.accel_x_mg, in_q.accel_y_mg, in_q.accel_z_mg}),
    .tare_i  (tare_q),
    .mag_o   (mag)
  );

  always_comb begin
    fin_b  = fin_q & ~in_q.start_run;
    cmd_b  = cmd_sent_q & ~in_q.start_run;
    active = ~fin_b;
    // values are cleared on a start pulse and on the first tick of a run
    clr    = in_q.start_run | ~cmd_sent_q;

    tick_d = in_q.start_run ? '0 : tick_q;
    if (active && tick_d != CntMax) tick_d = tick_d + CntW'(1);

    travel_d   = clr ? '0 : travel_q;
    sum_x_d    = clr ? '0 : sum_x_q;
    sum_y_d    = clr ? '0 : sum_y_q;
    sum_z_d    = clr ? '0 : sum_z_q;
    last_id_d  = clr ? '0 : last_id_q;
    have_id_d  = clr ? 1'b0 : have_id_q;
    count_d    = clr ? '0 : count_q;
    last_mag_d = clr ? '0 : last_mag_q;
    peak_mag_d = clr ? '0 : peak_mag_q;

    step_abs   = in_q.travel_step_um[StepW-1] ? StepW'(-in_q.travel_step_um)
                                              : StepW'(in_q.travel_step_um);
    travel_sum = {1'b0, travel_d} + (TravelW+1)'(step_abs);
    if (active && in_q.motion_valid) begin
      travel_d = travel_sum[TravelW] ? TravelMax : travel_sum[TravelW-1:0];
    end

    take = active & in_q.sample_valid &
           ~(have_id_d & (last_id_d == in_q.sample_id));
    if (take) begin
      sum_x_d    = sum_x_d + SumW'(in_q.raw_x);
      sum_y_d    = sum_y_d + SumW'(in_q.raw_y);
      sum_z_d    = sum_z_d + SumW'(in_q.raw_z);
      last_id_d  = in_q.sample_id;
      have_id_d  = 1'b1;
      if (count_d != CntMax) count_d = count_d + CntW'(1);
      last_mag_d = mag;
      if (mag > peak_mag_d) peak_mag_d = mag;
    end

    tick_limit = tick_d >= max_ticks_q;
    last_x4    = {last_mag_d, QuarterShift'(0)};
    priority if (travel_d >= max_travel_q)  decel = 1'b1;
    else if (travel_d < min_travel_q)       decel = 1'b0;
    else if (count_d < min_samples_q)       decel = 1'b0;
    else if (peak_mag_d == '0)              decel = 1'b0;
    else decel = last_x4 < (MagW+QuarterShift)'(peak_mag_d);

    stop       = active & (tick_limit | decel);
    fin_d      = fin_b | stop;
    failed_d   = (failed_q & ~in_q.start_run) |
                 (stop & (tick_limit | (count_d < min_samples_q)));
    cmd_sent_d = cmd_b | active;

    // zero command wins when a run starts and stops on one tick
    mwrite = active & (~cmd_b | stop);
    mvalue = (active & ~cmd_b & ~stop) ? drive_cmd_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q      <= 1'b0;
      failed_q   <= 1'b0;
      cmd_sent_q <= 1'b0;
      have_id_q  <= 1'b0;
      tick_q     <= '0;
      count_q    <= '0;
      last_id_q  <= '0;
      travel_q   <= '0;
      sum_x_q    <= '0;
      sum_y_q    <= '0;
      sum_z_q    <= '0;
      last_mag_q <= '0;
      peak_mag_q <= '0;
    end else if (advance) begin
      fin_q      <= fin_d;
      failed_q   <= failed_d;
      cmd_sent_q <= cmd_sent_d;
      have_id_q  <= have_id_d;
      tick_q     <= tick_d;
      count_q    <= count_d;
      last_id_q  <= last_id_d;
      travel_q   <= travel_d;
      sum_x_q    <= sum_x_d;
      sum_y_q    <= sum_y_d;
      sum_z_q    <= sum_z_d;
      last_mag_q <= last_mag_d;
      peak_mag_q <= peak_mag_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      run_finished_o    <= fin_d;
      run_failed_o      <= failed_d;
      motor_write_o     <= mwrite;
      motor_value_o     <= mvalue;
      samples_taken_o   <= count_d;
      travel_total_um_o <= travel_d;
      last_magnitude_o  <= last_mag_d;
      peak_magnitude_o  <= peak_mag_d;
      sum_x_o           <= sum_x_d;
      sum_y_o           <= sum_y_d;
      sum_z_o           <= sum_z_d;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule
`default_nettype wire

// ===== dv/tb_drive_and_sample_sequencer.sv =====
import dss_pkg::*;

typedef struct packed {
  logic                    finished;
  logic                    failed;
  logic                    mwrite;
  logic signed [AxisW-1:0] mvalue;
  logic [CntW-1:0]         samples;
  logic [TravelW-1:0]      travel;
  logic [MagW-1:0]         last_mag;
  logic [MagW-1:0]         peak_mag;
  logic signed [SumW-1:0]  sum_x;
  logic signed [SumW-1:0]  sum_y;
  logic signed [SumW-1:0]  sum_z;
} tick_status_t;

class run_status_board;
  // register copies
  logic signed [AxisW-1:0] drive_cmd;
  logic signed [AxisW-1:0] tare_x, tare_y, tare_z;
  logic [TravelW-1:0]      max_travel, min_travel;
  logic [CntW-1:0]         min_samples, max_ticks;

  // run state
  bit                      run_done, run_failed, drive_sent, have_id;
  logic [CntW-1:0]         ticks, samples, last_id;
  logic [TravelW-1:0]      travel;
  logic [SumW-1:0]         sum_x, sum_y, sum_z;
  logic [MagW-1:0]         last_mag, peak_mag;

  tick_status_t            status_due[$];
  int                      errors, accepted, checked, stops, failed_stops;

  function new();
    drive_cmd   = '0;
    tare_x      = '0;
    tare_y      = '0;
    tare_z      = '0;
    max_travel  = '0;
    min_travel  = '0;
    min_samples = MinSamplesRst;
    max_ticks   = MaxTicksRst;
    run_done    = 0;
    run_failed  = 0;
    drive_sent  = 0;
    ticks       = '0;
    clear_run();
  endfunction

  function void clear_run();
    travel   = '0;
    sum_x    = '0;
    sum_y    = '0;
    sum_z    = '0;
    last_id  = '0;
    have_id  = 0;
    samples  = '0;
    last_mag = '0;
    peak_mag = '0;
  endfunction

  function void write_reg(cfg_index_e idx, logic [CfgDataW-1:0] val);
    case (idx)
      CFG_DRIVE_COMMAND: drive_cmd   = val[AxisW-1:0];
      CFG_TARE_X:        tare_x      = val[AxisW-1:0];
      CFG_TARE_Y:        tare_y      = val[AxisW-1:0];
      CFG_TARE_Z:        tare_z      = val[AxisW-1:0];
      CFG_MAX_TRAVEL:    max_travel  = val[TravelW-1:0];
      CFG_MIN_TRAVEL:    min_travel  = val[TravelW-1:0];
      CFG_MIN_SAMPLES:   min_samples = val[CntW-1:0];
      CFG_MAX_TICKS:     max_ticks   = val[CntW-1:0];
      default: ;
    endcase
  endfunction

  function logic [16:0] axis_dist(logic [15:0] a, logic [15:0] b);
    logic signed [16:0] d;
    d = $signed({a[15], a}) - $signed({b[15], b});
    return d[16] ? 17'(-d) : 17'(d);
  endfunction

  function void predict_tick(in_item_t t);
    tick_status_t      r;
    logic [StepW-1:0]  step_abs;
    logic [TravelW:0]  trav_sum;
    bit                tick_limit, stop;
    r = '0;
    accepted++;
    if (t.start_run) begin
      run_done   = 0;
      run_failed = 0;
      drive_sent = 0;
      ticks      = '0;
      clear_run();
    end
    if (!run_done) begin
      if (!drive_sent) begin
        clear_run();
        r.mwrite   = 1'b1;
        r.mvalue   = drive_cmd;
        drive_sent = 1;
      end
      if (ticks != CntMax) ticks++;
      if (t.motion_valid) begin
        step_abs = t.travel_step_um[StepW-1] ? StepW'(-t.travel_step_um)
                                             : StepW'(t.travel_step_um);
        trav_sum = {1'b0, travel} + (TravelW+1)'(step_abs);
        travel   = trav_sum[TravelW] ? TravelMax : trav_sum[TravelW-1:0];
      end
      if (t.sample_valid && !(have_id && last_id == t.sample_id)) begin
        sum_x   = sum_x + {{16{t.raw_x[15]}}, t.raw_x};
        sum_y   = sum_y + {{16{t.raw_y[15]}}, t.raw_y};
        sum_z   = sum_z + {{16{t.raw_z[15]}}, t.raw_z};
        last_id = t.sample_id;
        have_id = 1;
        if (samples != CntMax) samples++;
        last_mag = MagW'(axis_dist(t.accel_x_mg, tare_x)) +
                   MagW'(axis_dist(t.accel_y_mg, tare_y)) +
                   MagW'(axis_dist(t.accel_z_mg, tare_z));
        if (last_mag > peak_mag) peak_mag = last_mag;
      end
      tick_limit = ticks >= max_ticks;
      stop = tick_limit || travel >= max_travel;
      if (!stop && travel >= min_travel && samples >= min_samples && peak_mag != '0 &&
          {last_mag, 2'b00} < 20'(peak_mag))
        stop = 1;
      if (stop) begin
        r.mwrite = 1'b1;
        r.mvalue = '0;
        run_done = 1;
        stops++;
        if (tick_limit || samples < min_samples) begin
          run_failed = 1;
          failed_stops++;
        end
      end
    end
    r.finished = run_done;
    r.failed   = run_failed;
    r.samples  = samples;
    r.travel   = travel;
    r.last_mag = last_mag;
    r.peak_mag = peak_mag;
    r.sum_x    = sum_x;
    r.sum_y    = sum_y;
    r.sum_z    = sum_z;
    status_due.push_back(r);
  endfunction

  task report(string what);
    errors++;
    $display("MISMATCH: %s", what);
  endtask

  task field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report($sformatf("result %0d %s: got %0h want %0h", checked, name, got, want));
  endtask

  task check_status(tick_status_t got);
    tick_status_t want;
    if (status_due.size() == 0) begin
      report("result beat with nothing expected");
      return;
    end
    want = status_due.pop_front();
    field("run_finished", 64'(got.finished), 64'(want.finished));
    field("run_failed", 64'(got.failed), 64'(want.failed));
    field("motor_write", 64'(got.mwrite), 64'(want.mwrite));
    field("motor_value", 64'(got.mvalue), 64'(want.mvalue));
    field("samples_taken", 64'(got.samples), 64'(want.samples));
    field("travel_total_um", 64'(got.travel), 64'(want.travel));
    field("last_magnitude", 64'(got.last_mag), 64'(want.last_mag));
    field("peak_magnitude", 64'(got.peak_mag), 64'(want.peak_mag));
    field("sum_x", 64'(got.sum_x), 64'(want.sum_x));
    field("sum_y", 64'(got.sum_y), 64'(want.sum_y));
    field("sum_z", 64'(got.sum_z), 64'(want.sum_z));
    checked++;
  endtask
endclass

module tb_drive_and_sample_sequencer;

  localparam int RandomTicks = 500;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIdxW-1:0]      cfg_index_i = '0;
  logic [CfgDataW-1:0]     cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic                    start_run_i = 1'b0;
  logic                    motion_valid_i = 1'b0;
  logic signed [StepW-1:0] travel_step_um_i = '0;
  logic                    sample_valid_i = 1'b0;
  logic [AxisW-1:0]        sample_id_i = '0;
  logic signed [AxisW-1:0] raw_x_i = '0;
  logic signed [AxisW-1:0] raw_y_i = '0;
  logic signed [AxisW-1:0] raw_z_i = '0;
  logic signed [AxisW-1:0] accel_x_mg_i = '0;
  logic signed [AxisW-1:0] accel_y_mg_i = '0;
  logic signed [AxisW-1:0] accel_z_mg_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic                    run_finished_o;
  logic                    run_failed_o;
  logic                    motor_write_o;
  logic signed [AxisW-1:0] motor_value_o;
  logic [CntW-1:0]         samples_taken_o;
  logic [TravelW-1:0]      travel_total_um_o;
  logic [MagW-1:0]         last_magnitude_o;
  logic [MagW-1:0]         peak_magnitude_o;
  logic signed [SumW-1:0]  sum_x_o;
  logic signed [SumW-1:0]  sum_y_o;
  logic signed [SumW-1:0]  sum_z_o;

  run_status_board board = new();
  tick_status_t    seen;
  bit              no_idle = 0;
  int              setups = 0;

  drive_and_sample_sequencer uut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .start_run_i, .motion_valid_i, .travel_step_um_i,
    .sample_valid_i, .sample_id_i, .raw_x_i, .raw_y_i, .raw_z_i,
    .accel_x_mg_i, .accel_y_mg_i, .accel_z_mg_i,
    .out_valid_o, .out_ready_i, .run_finished_o, .run_failed_o, .motor_write_o,
    .motor_value_o, .samples_taken_o, .travel_total_um_o, .last_magnitude_o,
    .peak_magnitude_o, .sum_x_o, .sum_y_o, .sum_z_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("drive_and_sample_sequencer test failed");
    $finish;
  end

  always @(negedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(0, 99) >= 6);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.finished = run_finished_o;
      seen.failed   = run_failed_o;
      seen.mwrite   = motor_write_o;
      seen.mvalue   = motor_value_o;
      seen.samples  = samples_taken_o;
      seen.travel   = travel_total_um_o;
      seen.last_mag = last_magnitude_o;
      seen.peak_mag = peak_magnitude_o;
      seen.sum_x    = sum_x_o;
      seen.sum_y    = sum_y_o;
      seen.sum_z    = sum_z_o;
      board.check_status(seen);
    end
  end

  // called and returns at a falling edge
  task automatic send_tick(in_item_t t);
    if (!no_idle && $urandom_range(0, 99) < 6) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    start_run_i      <= t.start_run;
    motion_valid_i   <= t.motion_valid;
    travel_step_um_i <= t.travel_step_um;
    sample_valid_i   <= t.sample_valid;
    sample_id_i      <= t.sample_id;
    raw_x_i          <= t.raw_x;
    raw_y_i          <= t.raw_y;
    raw_z_i          <= t.raw_z;
    accel_x_mg_i     <= t.accel_x_mg;
    accel_y_mg_i     <= t.accel_y_mg;
    accel_z_mg_i     <= t.accel_z_mg;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.predict_tick(t);
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (board.status_due.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.write_reg(idx, val);
    @(negedge clk_i);
  endtask

  // block idle: no tick in flight before any register changes
  task automatic load_setup(logic [15:0] drv, logic [15:0] tx, logic [15:0] ty,
                            logic [15:0] tz, logic [39:0] maxtr, logic [39:0] mintr,
                            logic [15:0] mins, logic [15:0] maxt);
    in_valid_i <= 1'b0;
    drain();
    write_reg(CFG_DRIVE_COMMAND, 40'(drv));
    write_reg(CFG_TARE_X, 40'(tx));
    write_reg(CFG_TARE_Y, 40'(ty));
    write_reg(CFG_TARE_Z, 40'(tz));
    write_reg(CFG_MAX_TRAVEL, maxtr);
    write_reg(CFG_MIN_TRAVEL, mintr);
    write_reg(CFG_MIN_SAMPLES, 40'(mins));
    write_reg(CFG_MAX_TICKS, 40'(maxt));
    cfg_valid_i <= 1'b0;
    setups++;
  endtask

  function automatic in_item_t random_tick();
    in_item_t t;
    t.start_run      = ($urandom_range(0, 9) == 0);
    t.motion_valid   = 1'($urandom_range(0, 1));
    t.travel_step_um = StepW'($urandom);
    t.sample_valid   = 1'($urandom_range(0, 1));
    t.sample_id      = ($urandom_range(0, 3) == 0) ? board.last_id : 16'($urandom);
    t.raw_x          = 16'($urandom);
    t.raw_y          = 16'($urandom);
    t.raw_z          = 16'($urandom);
    t.accel_x_mg     = 16'($urandom);
    t.accel_y_mg     = 16'($urandom);
    t.accel_z_mg     = 16'($urandom);
    return t;
  endfunction

  function automatic in_item_t mk_tick(bit start, bit mv, logic [23:0] step, bit sv,
                                       logic [15:0] id, logic [15:0] raw,
                                       logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
    in_item_t t;
    t.start_run      = start;
    t.motion_valid   = mv;
    t.travel_step_um = step;
    t.sample_valid   = sv;
    t.sample_id      = id;
    t.raw_x          = raw;
    t.raw_y          = ~raw;
    t.raw_z          = raw;
    t.accel_x_mg     = ax;
    t.accel_y_mg     = ay;
    t.accel_z_mg     = az;
    return t;
  endfunction

  function automatic logic [15:0] small_tare();
    return 16'($urandom_range(0, 400)) - 16'd200;
  endfunction

  task automatic random_setup();
    logic [15:0] drv, tx, ty, tz, mins, maxt;
    logic [39:0] maxtr, mintr;
    drv = 16'($urandom);
    case ($urandom_range(0, 7))
      0: drv = 16'h8000;
      1: drv = 16'h7fff;
      2: drv = '0;
      default: ;
    endcase
    tx = small_tare();
    ty = small_tare();
    tz = small_tare();
    if ($urandom_range(0, 7) == 0) begin
      tx = 16'($urandom);
      ty = 16'($urandom);
      tz = 16'($urandom);
    end
    case ($urandom_range(0, 9))
      0: maxtr = '1;
      1: maxtr = 40'($urandom_range(0, 3000));
      2: maxtr = 40'({$urandom, $urandom});
      default: maxtr = 40'($urandom_range(100000, 600000));
    endcase
    case ($urandom_range(0, 9))
      0: mintr = '1;
      1: mintr = '0;
      default: mintr = 40'($urandom_range(0, 40000));
    endcase
    case ($urandom_range(0, 9))
      0: mins = 16'hffff;
      1: mins = '0;
      default: mins = 16'($urandom_range(1, 5));
    endcase
    case ($urandom_range(0, 9))
      0: maxt = 16'hffff;
      1: maxt = 16'd1;
      default: maxt = 16'($urandom_range(6, 40));
    endcase
    load_setup(drv, tx, ty, tz, maxtr, mintr, mins, maxt);
  endtask

  // start pulse, steady motion, fresh sample ids, magnitude rising to a peak and
  // then decaying, so the deceleration stop gets a chance to fire
  task automatic shaped_run();
    in_item_t    t;
    int          n, peak_at, amp, sgn;
    logic [15:0] id;
    id      = 16'($urandom);
    n       = 0;
    peak_at = $urandom_range(1, 8);
    do begin
      no_idle = (board.accepted >= 250 && board.accepted < 350);
      t = random_tick();
      t.start_run    = (n == 0);
      t.motion_valid = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 15) != 0) begin
        sgn = $urandom_range(0, 1) ? -1 : 1;
        t.travel_step_um = StepW'(sgn * $urandom_range(0, 20000));
      end
      t.sample_valid = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 7) != 0) id++;
      t.sample_id = id;
      amp = (n <= peak_at) ? 400 * (n + 1) : (400 * (peak_at + 1)) >> (2 * (n - peak_at));
      amp = amp + $urandom_range(0, 20);
      sgn = $urandom_range(0, 1) ? -1 : 1;
      t.accel_x_mg = 16'(int'(board.tare_x) + sgn * amp / 2);
      t.accel_y_mg = 16'(int'(board.tare_y) - sgn * amp / 4);
      t.accel_z_mg = 16'(int'(board.tare_z) + amp / 4);
      send_tick(t);
      n++;
    end while (!board.run_done && n < 40);
    // ticks after the stop must hold everything
    repeat ($urandom_range(0, 2)) begin
      t = random_tick();
      t.start_run = 1'b0;
      send_tick(t);
    end
  endtask

  initial begin
    int          base;
    int          runs;
    in_item_t    t;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // defaults: zero travel limit stops the run on its first tick
    send_tick(mk_tick(1, 1, 24'h800000, 1, 16'h0000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000));
    send_tick(random_tick());
    t = mk_tick(1, 0, 24'h7fffff, 0, 16'hffff, 16'h7fff, 16'h0, 16'h0, 16'h0);
    send_tick(t);

    load_setup(16'h8000, 16'h7fff, 16'h8000, 16'h0000, '1, '0, 16'd2, 16'hffff);
    send_tick(mk_tick(1, 1, 24'h7fffff, 1, 16'hffff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
    send_tick(mk_tick(0, 1, 24'h800000, 1, 16'hffff, 16'h8000, 16'h1234, 16'h0, 16'h0));
    send_tick(mk_tick(0, 1, 24'h000001, 0, 16'h0001, 16'h5555, 16'h0, 16'h0, 16'h0));
    // magnitude back to zero: below a quarter of the peak
    send_tick(mk_tick(0, 0, 24'h0, 1, 16'h0000, 16'haaaa, 16'h7fff, 16'h8000, 16'h0000));
    send_tick(mk_tick(0, 1, 24'h123456, 1, 16'h0002, 16'h7fff, 16'h0, 16'h0, 16'h0));
    send_tick(mk_tick(1, 0, 24'h0, 1, 16'h0000, 16'h0001, 16'h7fff, 16'h7fff, 16'h7fff));
    send_tick(mk_tick(0, 1, 24'hffffff, 1, 16'h0000, 16'hffff, 16'h0, 16'h0, 16'h0));
    send_tick(mk_tick(1, 1, 24'h000010, 1, 16'h0003, 16'h0100, 16'h8000, 16'h7fff, 16'h0));

    // zero tick limit: times out on the first tick
    load_setup(16'h7fff, 16'h0, 16'h0, 16'h0, '1, '0, 16'h0, 16'h0);
    send_tick(mk_tick(1, 1, 24'h000100, 1, 16'h0010, 16'h0001, 16'h0100, 16'h0, 16'h0));
    send_tick(mk_tick(0, 1, 24'h000100, 1, 16'h0011, 16'h0001, 16'h0100, 16'h0, 16'h0));

    // unreachable travel and sample needs: only the timeout can end it
    load_setup(16'h0000, 16'h0, 16'h0, 16'h0, '1, '1, 16'hffff, 16'd3);
    send_tick(mk_tick(1, 1, 24'h7fffff, 1, 16'h0020, 16'h0002, 16'h1000, 16'h0, 16'h0));
    send_tick(mk_tick(0, 1, 24'h800000, 1, 16'h0021, 16'hfffe, 16'h0010, 16'h0, 16'h0));
    send_tick(mk_tick(0, 1, 24'h7fffff, 1, 16'h0022, 16'h0003, 16'h0001, 16'h0, 16'h0));
    send_tick(mk_tick(0, 0, 24'h0, 0, 16'h0023, 16'h0, 16'h0, 16'h0, 16'h0));

    base = board.accepted;
    runs = 0;
    while (board.accepted - base < RandomTicks) begin
      if (runs % 4 == 0) random_setup();
      if ($urandom_range(0, 4) != 0) begin
        shaped_run();
      end else begin
        repeat ($urandom_range(3, 10)) send_tick(random_tick());
      end
      runs++;
    end
    no_idle = 0;

    in_valid_i <= 1'b0;
    drain();
    repeat (5) @(posedge clk_i);
    if (board.status_due.size() != 0) board.report("expected results left over");
    $display("checked %0d result beats over %0d register setups", board.checked, setups);
    $display("runs stopped: %0d, of which flagged failed: %0d",
             board.stops, board.failed_stops);
    if (board.errors == 0) begin
      $display("drive_and_sample_sequencer test passed");
    end else begin
      $display("drive_and_sample_sequencer test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/dss_pkg.sv
hw/rtl/dss_mag.sv
hw/rtl/drive_and_sample_sequencer.sv
dv/tb_drive_and_sample_sequencer.sv
